### rtl/core/bma3_pkg.sv
// Shared widths and result field layout for the baseline moving average block.
package bma3_pkg;

  localparam int ANGLE_W = 16;
  localparam int DEV_W   = 17;
  localparam int SUM_W   = 21;

  // Result word: six deviations, then three window sums, lowest bit first.
  localparam int OUT_BITS    = 6 * DEV_W + 3 * SUM_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int DEV_X_LSB   = 3 * DEV_W;
  localparam int SUM_X_LSB   = 6 * DEV_W;

endpackage

### rtl/core/baseline_moving_average_3axis.sv
// Baseline deviation of six sensor values and moving window sums of the acceleration deviations.
//
//  channel  | dir | fields (tdata, lowest bit first)
//  s_axis   | in  | yaw_in, pitch_in, roll_in, accel_x, accel_y, accel_z
//  m_axis   | out | yaw_dev, pitch_dev, roll_dev, dev_x, dev_y, dev_z, sum_x, sum_y, sum_z
//
// One sample per cycle unless m_axis stalls; each passes the s1 stage, then the output register.
// The ring memory has one port for reads and one for writes. Each sample reads the
// oldest entry when it is taken, and writes its deviation back when it moves to the output.
// After reset the baseline is open and the rings read as zero until filled once.
// A stall on m_axis holds the result register, and s_axis then takes at most one more sample.
module baseline_moving_average_3axis
  import bma3_pkg::*;
#(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_TDATA_W = ((3 * ANGLE_W + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // yaw_in, pitch_in, roll_in, accel_x, accel_y, accel_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // yaw_dev, pitch_dev, roll_dev, dev_x, dev_y, dev_z, sum_x, sum_y, sum_z
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int RING_W = SAMPLE_BITS + 1;
  localparam int ACC_W  = (RING_W > SUM_W) ? RING_W : SUM_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic s_acc, s1_move;

  logic signed [ANGLE_W-1:0]     ang [3];
  logic signed [SAMPLE_BITS-1:0] acc [3];
  logic signed [DEV_W-1:0]       ang_dev [3];
  logic signed [RING_W-1:0]      acc_dev [3];

  logic signed [ANGLE_W-1:0]     base_ang_q [3];
  logic signed [SAMPLE_BITS-1:0] base_acc_q [3];
  logic                          taken_q;

  logic [SLOT_W-1:0] slot_q;
  logic              filled_q;

  logic [3*RING_W-1:0] ring_mem [WINDOW];
  logic [3*RING_W-1:0] rd_q;
  logic [3*RING_W-1:0] wr_word;

  logic                     s1_valid_q;
  logic signed [DEV_W-1:0]  s1_ang_dev_q [3];
  logic signed [RING_W-1:0] s1_acc_dev_q [3];
  logic [SLOT_W-1:0]        s1_slot_q;
  logic                     s1_old_valid_q;

  logic signed [SUM_W-1:0]  sum_q [3];
  logic signed [SUM_W-1:0]  sum_d [3];
  logic signed [RING_W-1:0] old_dev [3];
  logic signed [ACC_W-1:0]  old_ext [3];

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] out_data_d;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The first sample is its own baseline, so its deviations come out zero.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ang[k] = s_axis_tdata[k*ANGLE_W +: ANGLE_W];
      acc[k] = s_axis_tdata[3*ANGLE_W + k*SAMPLE_BITS +: SAMPLE_BITS];
      ang_dev[k] = (taken_q ? DEV_W'(base_ang_q[k]) : DEV_W'(ang[k])) - DEV_W'(ang[k]);
      acc_dev[k] = (taken_q ? RING_W'(base_acc_q[k]) : RING_W'(acc[k])) - RING_W'(acc[k]);
    end
  end

  // An entry that has not been written since reset counts as zero.
  always_comb begin
    out_data_d = '0;
    wr_word    = '0;
    for (int k = 0; k < 3; k++) begin
      old_dev[k] = rd_q[k*RING_W +: RING_W];
      old_ext[k] = s1_old_valid_q ? ACC_W'(old_dev[k]) : '0;
      sum_d[k]   = SUM_W'(ACC_W'(sum_q[k]) + ACC_W'(s1_acc_dev_q[k]) - old_ext[k]);
      wr_word[k*RING_W +: RING_W] = s1_acc_dev_q[k];
      out_data_d[k*DEV_W +: DEV_W]               = s1_ang_dev_q[k];
      out_data_d[DEV_X_LSB + k*DEV_W +: DEV_W]   = DEV_W'(s1_acc_dev_q[k]);
      out_data_d[SUM_X_LSB + k*SUM_W +: SUM_W]   = sum_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      rd_q <= ring_mem[slot_q];
    end
    if (s1_move) begin
      ring_mem[s1_slot_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      if (!taken_q) begin
        base_ang_q <= ang;
        base_acc_q <= acc;
      end
      s1_ang_dev_q   <= ang_dev;
      s1_acc_dev_q   <= acc_dev;
      s1_slot_q      <= slot_q;
      s1_old_valid_q <= filled_q;
    end
    if (s1_move) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= 1'b0;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      if (s_acc) begin
        taken_q <= 1'b1;
        if (slot_q == LAST_SLOT) begin
          slot_q   <= '0;
          filled_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        sum_q       <= sum_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/bma3_checker.sv
// Port-level checks for the baseline moving average block, bound to its top level.
module bma3_checker
  import bma3_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int IN_TDATA_W  = 96
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Number of results delivered since reset, held at two.
  logic [1:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready && out_cnt_q != 2'd2) begin
      out_cnt_q <= out_cnt_q + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is free");

  // The first sample is its own baseline: all deviations and sums are zero.
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_cnt_q == 2'd0 |-> m_axis_tdata[OUT_BITS-1:0] == '0)
    else $error("first result is not zero");

  // The second sum holds only the second deviation, as the first one is zero.
  a_second_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_cnt_q == 2'd1 && SAMPLE_BITS < DEV_W |->
      m_axis_tdata[SUM_X_LSB +: SUM_W] ==
      SUM_W'(signed'(m_axis_tdata[DEV_X_LSB +: DEV_W])))
    else $error("second window sum does not match its deviation");

endmodule

bind baseline_moving_average_3axis bma3_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .IN_TDATA_W (IN_TDATA_W)
) u_bma3_checker (.*);

### tb/tb_baseline_moving_average_3axis.sv
// Self-checking testbench for the baseline deviation and moving window sum block.
module tb_baseline_moving_average_3axis;
  timeunit 1ns;
  timeprecision 1ps;
  import bma3_pkg::*;

  localparam int AXES       = 3;
  localparam int WIN        = 10;
  localparam int ACC_W      = 16;
  localparam int IN_W       = 3 * ANGLE_W + 3 * ACC_W;
  localparam int RAND_ITEMS = 1650;
  localparam int HOLD_AT    = 600;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic signed [ANGLE_W-1:0] ang [AXES];
    logic signed [ACC_W-1:0]   acc [AXES];
  } sample_t;

  typedef struct {
    logic signed [DEV_W-1:0] dev [2*AXES];
    logic signed [SUM_W-1:0] sum [AXES];
  } result_t;

  typedef struct {
    sample_t smp;
    bit      has_exp;
    result_t want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // yaw_in, pitch_in, roll_in, accel_x, accel_y, accel_z
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // yaw_dev, pitch_dev, roll_dev, dev_x, dev_y, dev_z, sum_x, sum_y, sum_z
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state.
  int base_ang [AXES];
  int base_acc [AXES];
  bit base_taken;
  int ring [AXES][WIN];
  int wr_slot;
  int run_sum [AXES];

  result_t   pending_results [$];
  stim_row_t dir_tab [$];
  int        err_cnt;
  int        accepted_cnt;
  string     dev_names [2*AXES] = '{"yaw_dev", "pitch_dev", "roll_dev",
                                    "dev_x", "dev_y", "dev_z"};
  string     sum_names [AXES] = '{"sum_x", "sum_y", "sum_z"};

  baseline_moving_average_3axis dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic sample_t mk_sample(int y, int p, int r, int x, int yy, int z);
    sample_t s;
    s.ang = '{ANGLE_W'(y), ANGLE_W'(p), ANGLE_W'(r)};
    s.acc = '{ACC_W'(x), ACC_W'(yy), ACC_W'(z)};
    return s;
  endfunction

  function automatic result_t mk_result(int dy, int dp, int dr, int dx, int dyy, int dz,
                                        int sx, int sy, int sz);
    result_t r;
    r.dev = '{DEV_W'(dy), DEV_W'(dp), DEV_W'(dr), DEV_W'(dx), DEV_W'(dyy), DEV_W'(dz)};
    r.sum = '{SUM_W'(sx), SUM_W'(sy), SUM_W'(sz)};
    return r;
  endfunction

  // Deviation from the captured baseline plus the running window sums.
  function automatic result_t predict_deviation(sample_t s);
    result_t r;
    int      d;
    if (!base_taken) begin
      for (int k = 0; k < AXES; k++) begin
        base_ang[k] = s.ang[k];
        base_acc[k] = s.acc[k];
      end
      base_taken = 1'b1;
    end
    for (int k = 0; k < AXES; k++) begin
      r.dev[k] = DEV_W'(base_ang[k] - int'(s.ang[k]));
      d = base_acc[k] - int'(s.acc[k]);
      r.dev[AXES+k] = DEV_W'(d);
      run_sum[k] += d - ring[k][wr_slot];
      ring[k][wr_slot] = d;
      r.sum[k] = SUM_W'(run_sum[k]);
    end
    wr_slot = (wr_slot + 1) % WIN;
    return r;
  endfunction

  function automatic int clamp_acc(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      v;
    for (int k = 0; k < AXES; k++) begin
      if ($urandom_range(0, 7) == 0)
        s.ang[k] = ($urandom_range(0, 1) != 0) ? ANGLE_W'(18000) : ANGLE_W'(-18000);
      else
        s.ang[k] = ANGLE_W'(int'($urandom_range(0, 36000)) - 18000);
      case ($urandom_range(0, 9))
        0: s.acc[k] = ($urandom_range(0, 1) != 0) ? ACC_W'(32767) : ACC_W'(-32768);
        1, 2: begin
          v = base_acc[k] + int'($urandom_range(0, 200)) - 100;
          s.acc[k] = ACC_W'(clamp_acc(v));
        end
        default: s.acc[k] = ACC_W'($urandom());
      endcase
    end
    return s;
  endfunction

  task automatic add_row(sample_t s, bit has_exp, result_t want);
    stim_row_t row;
    row.smp = s;
    row.has_exp = has_exp;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Offers one sample and waits for its transfer; the prediction is queued then.
  task automatic send_sample(sample_t s, bit has_exp, result_t want);
    result_t pred;
    s_axis_tdata  <= {s.acc[2], s.acc[1], s.acc[0], s.ang[2], s.ang[1], s.ang[0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_deviation(s);
    pending_results.push_back(has_exp ? want : pred);
    accepted_cnt++;
  endtask

  int burst_left;

  // Bursts of back-to-back samples separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic check_result();
    result_t                 want;
    logic signed [DEV_W-1:0] got_dev;
    logic signed [SUM_W-1:0] got_sum;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no sample pending", 0, 0);
      return;
    end
    want = pending_results.pop_front();
    for (int k = 0; k < 2 * AXES; k++) begin
      got_dev = m_axis_tdata[k*DEV_W +: DEV_W];
      if (got_dev !== want.dev[k]) report_mismatch(dev_names[k], got_dev, want.dev[k]);
    end
    for (int k = 0; k < AXES; k++) begin
      got_sum = m_axis_tdata[SUM_X_LSB + k*SUM_W +: SUM_W];
      if (got_sum !== want.sum[k]) report_mismatch(sum_names[k], got_sum, want.sum[k]);
    end
  endtask

  // Receiver: cycles through ready patterns, with one long hold-off to back up the input.
  initial begin
    int cyc;
    int hold_cnt;
    bit held;
    bit ready_next;
    cyc = 0;
    hold_cnt = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      cyc++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        ready_next = 1'b0;
      end else if (!held && accepted_cnt >= HOLD_AT) begin
        held = 1'b1;
        hold_cnt = HOLD_LEN;
        ready_next = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = (cyc % 5) != 0;
          default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      if (!rst_ni) ready_next = 1'b0;
      m_axis_tready <= ready_next;
    end
  end

  initial begin
    result_t no_exp;
    no_exp = mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0);
    err_cnt = 0;
    accepted_cnt = 0;
    burst_left = 0;
    base_taken = 1'b0;
    wr_slot = 0;
    for (int k = 0; k < AXES; k++) begin
      base_ang[k] = 0;
      base_acc[k] = 0;
      run_sum[k] = 0;
      for (int j = 0; j < WIN; j++) ring[k][j] = 0;
    end

    // The first sample becomes the baseline, so its deviations and sums are zero.
    add_row(mk_sample(18000, -18000, 18000, 32767, -32768, 32767), 1'b1,
            mk_result(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Opposite extremes while the window fills.
    for (int i = 1; i < WIN; i++)
      add_row(mk_sample(-18000, 18000, -18000, -32768, 32767, -32768), 1'b0, no_exp);
    // A full window of the widest deviations gives the extreme sums.
    add_row(mk_sample(-18000, 18000, -18000, -32768, 32767, -32768), 1'b1,
            mk_result(36000, -36000, 36000, 65535, -65535, 65535,
                      655350, -655350, 655350));
    add_row(mk_sample(18000, -18000, 18000, 32767, -32768, 32767), 1'b0, no_exp);
    add_row(mk_sample(0, 0, 0, 0, 0, 0), 1'b0, no_exp);
    add_row(mk_sample(-1, -1, -1, -1, -1, -1), 1'b0, no_exp);
    add_row(mk_sample(1, -1, 1, 1, -1, 1), 1'b0, no_exp);
    add_row(mk_sample(18000, 18000, 18000, 32767, 32767, 32767), 1'b0, no_exp);
    add_row(mk_sample(-18000, -18000, -18000, -32768, -32768, -32768), 1'b0, no_exp);
    add_row(mk_sample(12345, -6789, 17999, 21845, -21846, 16384), 1'b0, no_exp);
    add_row(mk_sample(-17999, 9000, -4500, -16384, 10922, -10923), 1'b0, no_exp);
    add_row(mk_sample(100, -100, 0, 255, -256, 1), 1'b0, no_exp);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) begin
      pace_sender();
      send_sample(dir_tab[i].smp, dir_tab[i].has_exp, dir_tab[i].want);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pace_sender();
      send_sample(rand_sample(), 1'b0, no_exp);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
